@@ src/assert_macros.svh @@
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// concurrent assertion on the block clock and reset
`define ASSERT_DEF(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_DEF(lbl, prop)

`endif

`endif

@@ src/lcfr_pkg.sv @@
`default_nettype none

package lcfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CrcW-1:0]  CrcInit    = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcResidue = 16'hF0B8;
  localparam logic [CrcW-1:0]  CrcPoly    = 16'h8408;
  localparam logic [ByteW-1:0] MinLen     = 8'd4;
  localparam logic [ByteW-1:0] Overhead   = 8'd3;

  localparam logic [ByteW-1:0] MaxMsgLenReset  = 8'd255;
  localparam logic [ByteW-1:0] MaxDeliverReset = 8'd252;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMaxMsgLen  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegMaxDeliver = 8'd1;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_e;

  // reflected crc-16 ccitt, one byte
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/lcfr_intf.sv @@
`default_nettype none

// received byte channel
interface lcfr_rx_if import lcfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// result channel
interface lcfr_res_if import lcfr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ByteW-1:0] payload_byte;
  logic [ByteW-1:0] payload_index;
  logic [ByteW-1:0] frame_len;
  logic [ByteW-1:0] bad_count;
  logic [ByteW-1:0] good_count;

  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output frame_len, output bad_count, output good_count, input ready);
  modport sink (input valid, input kind, input payload_byte, input payload_index,
                input frame_len, input bad_count, input good_count, output ready);
endinterface

// configuration write channel
interface lcfr_cfg_if import lcfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/length_crc_frame_receiver_top.sv @@
// Length-prefixed frame receiver with CRC-16/X.25 check.
// rx_i carries one received serial byte per request. The first byte of a
// frame is its total length (length byte, payload, two FCS bytes); a length
// below 4 or above max_message_len yields a reject result (kind 3). Payload
// bytes come out on res_o as kind 0, up to max_deliver per frame; the last
// byte of a frame yields the verdict, kind 1 good or kind 2 bad. A consumer
// drops payload already taken when the verdict is bad.
// cfg_i writes register 0 (max_message_len) or 1 (max_deliver); it is always
// ready. The user must write it only while the block is idle; the block
// itself does not enforce this. A result is registered in the cycle after its
// byte is taken. It takes one byte per cycle while the result register is free,
// set by the byte-wide CRC update and the single result register.
// rx_i.ready is high while the result register is empty or being drained;
// if the receiver stalls with a result pending, input stalls too, and bytes
// that give no result are still held off until the register is free.
// Reset clears the frame state, both counters and the result valid, and
// loads the register defaults 255 and 252.
`default_nettype none

`include "assert_macros.svh"

module length_crc_frame_receiver_top import lcfr_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  lcfr_cfg_if.sink  cfg_i,
  lcfr_rx_if.sink   rx_i,
  lcfr_res_if.source res_o
);

  // configuration registers
  logic [ByteW-1:0] max_len_q, max_dlv_q;

  // frame state
  logic [ByteW-1:0] seen_q, seen_d;
  logic [ByteW-1:0] exp_q, exp_d;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [ByteW-1:0] bad_cnt_q, bad_cnt_d;
  logic [ByteW-1:0] good_cnt_q, good_cnt_d;

  // result register
  logic             out_valid_q;
  kind_e            kind_q, kind_d;
  logic [ByteW-1:0] pbyte_q, pbyte_d;
  logic [ByteW-1:0] pidx_q, pidx_d;
  logic [ByteW-1:0] flen_q, flen_d;
  logic [ByteW-1:0] bad_out_q, good_out_q;
  logic             emit_d;

  logic in_acc;

  assign cfg_i.ready = 1'b1;
  assign rx_i.ready  = !out_valid_q || res_o.ready;
  assign in_acc      = rx_i.valid && rx_i.ready;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxMsgLenReset;
      max_dlv_q <= MaxDeliverReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegMaxMsgLen:  max_len_q <= cfg_i.data;
        RegMaxDeliver: max_dlv_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // per-byte frame logic
  always_comb begin
    logic [CrcW-1:0]  crc_n;
    logic [ByteW-1:0] seen_n;
    logic [ByteW-1:0] idx;
    logic             good;
    logic [ByteW:0]   pos_end;
    crc_n      = crc_byte(crc_q, rx_i.rx_byte);
    seen_n     = seen_q + 8'd1;
    idx        = seen_q - 8'd1;
    good       = (crc_n == CrcResidue);
    pos_end    = {1'b0, seen_q} + {1'b0, Overhead};
    seen_d     = seen_q;
    exp_d      = exp_q;
    crc_d      = crc_q;
    bad_cnt_d  = bad_cnt_q;
    good_cnt_d = good_cnt_q;
    emit_d     = 1'b0;
    kind_d     = KIND_PAYLOAD;
    pbyte_d    = '0;
    pidx_d     = '0;
    flen_d     = exp_q;
    if (seen_q == '0) begin
      // waiting for a length byte
      if (rx_i.rx_byte < MinLen || rx_i.rx_byte > max_len_q) begin
        bad_cnt_d = bad_cnt_q + 8'd1;
        emit_d    = 1'b1;
        kind_d    = KIND_REJECT;
        flen_d    = rx_i.rx_byte;
      end else begin
        exp_d  = rx_i.rx_byte;
        crc_d  = crc_byte(CrcInit, rx_i.rx_byte);
        seen_d = 8'd1;
      end
    end else if (seen_n >= exp_q) begin
      // last byte of the frame: verdict
      if (good) begin
        good_cnt_d = good_cnt_q + 8'd1;
      end
      seen_d = '0;
      crc_d  = CrcInit;
      emit_d = 1'b1;
      kind_d = good ? KIND_GOOD : KIND_BAD;
    end else begin
      crc_d  = crc_n;
      seen_d = seen_n;
      // payload byte within the delivery limit
      if (pos_end <= {1'b0, exp_q} && idx < max_dlv_q) begin
        emit_d  = 1'b1;
        pbyte_d = rx_i.rx_byte;
        pidx_d  = idx;
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      exp_q      <= '0;
      crc_q      <= CrcInit;
      bad_cnt_q  <= '0;
      good_cnt_q <= '0;
    end else if (in_acc) begin
      seen_q     <= seen_d;
      exp_q      <= exp_d;
      crc_q      <= crc_d;
      bad_cnt_q  <= bad_cnt_d;
      good_cnt_q <= good_cnt_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= emit_d;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc && emit_d) begin
      kind_q     <= kind_d;
      pbyte_q    <= pbyte_d;
      pidx_q     <= pidx_d;
      flen_q     <= flen_d;
      bad_out_q  <= bad_cnt_d;
      good_out_q <= good_cnt_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.kind          = kind_q;
  assign res_o.payload_byte  = pbyte_q;
  assign res_o.payload_index = pidx_q;
  assign res_o.frame_len     = flen_q;
  assign res_o.bad_count     = bad_out_q;
  assign res_o.good_count    = good_out_q;

  // inside a frame the position stays below the expected length
  `ASSERT_DEF(a_seen_below_len, (seen_q != '0) |-> (seen_q < exp_q))
  // between frames the crc sits at its start value
  `ASSERT_DEF(a_crc_idle, (seen_q == '0) |-> (crc_q == CrcInit))
  // a delivered payload byte leaves room for the length byte and fcs
  `ASSERT_DEF(a_pidx_room, (out_valid_q && kind_q == KIND_PAYLOAD) |-> (pidx_q < flen_q - 8'd3))

endmodule

`default_nettype wire
